[hdl/acf_pkg.sv]
// acf_pkg: shared constants, types and field arithmetic for the configurable-field AES core
// no dependencies; imported by every module of the block except acf_ram
package acf_pkg;

    localparam int ROUND_COUNT = 10;
    localparam int KEY_WORDS   = 2 * (ROUND_COUNT + 1);
    localparam int KEY_AW      = $clog2(KEY_WORDS);
    localparam int KR_W        = $clog2(ROUND_COUNT + 1);
    localparam int TAB_DEPTH   = 512;
    localparam int TAB_AW      = $clog2(TAB_DEPTH);

    localparam logic [7:0] AFFINE_CONST = 8'h15;
    localparam logic [8:0] POLY_RESET   = 9'h11B;
    localparam logic [KR_W-1:0] LAST_ROUND = KR_W'(ROUND_COUNT);

    // configuration register indexes
    localparam int CFG_W = 3;
    localparam logic [CFG_W-1:0] CFG_POLY    = 3'd0;
    localparam logic [CFG_W-1:0] CFG_KEY_LO  = 3'd1;
    localparam logic [CFG_W-1:0] CFG_KEY_HI  = 3'd2;
    localparam logic [CFG_W-1:0] CFG_MIX_LO  = 3'd3;
    localparam logic [CFG_W-1:0] CFG_MIX_HI  = 3'd4;
    localparam logic [CFG_W-1:0] CFG_INV_LO  = 3'd5;
    localparam logic [CFG_W-1:0] CFG_INV_HI  = 3'd6;
    localparam logic [CFG_W-1:0] CFG_COUNT   = 3'd7;

    typedef struct packed {
        logic [8:0]   poly;
        logic [127:0] key;
        logic [127:0] mix;
        logic [127:0] inv;
    } t_cfg;

    // table memory access from the builder
    typedef struct packed {
        logic              we;
        logic [TAB_AW-1:0] waddr;
        logic [7:0]        wdata;
        logic [TAB_AW-1:0] raddr;
    } t_tab_req;

    // round key memory write from the builder
    typedef struct packed {
        logic              we;
        logic [KEY_AW-1:0] addr;
        logic [63:0]       data;
    } t_key_wr;

    // multiply in GF(2^8) modulo the given polynomial (bit 8 forced)
    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b,
                                        input logic [8:0] poly);
        logic [14:0] acc;
        logic [8:0]  p;
        acc = '0;
        p   = {1'b1, poly[7:0]};
        for (int i = 0; i < 8; i++) begin
            if (b[i]) acc = acc ^ (15'(a) << i);
        end
        for (int bt = 14; bt >= 8; bt--) begin
            if (acc[bt]) acc = acc ^ (15'(p) << (bt - 8));
        end
        return acc[7:0];
    endfunction

    // affine output map of the substitution box
    function automatic logic [7:0] affine(input logic [7:0] v);
        logic [7:0] s;
        s = '0;
        for (int j = 0; j < 8; j++) begin
            s[j] = v[j] ^ v[(j + 4) % 8] ^ v[(j + 5) % 8] ^ v[(j + 6) % 8]
                 ^ v[(j + 7) % 8] ^ AFFINE_CONST[j];
        end
        return s;
    endfunction

    // degree of a 9-bit polynomial, zero for zero
    function automatic logic [3:0] deg9(input logic [8:0] v);
        logic [3:0] d;
        d = '0;
        for (int i = 0; i < 9; i++) begin
            if (v[i]) d = 4'(i);
        end
        return d;
    endfunction

    // row rotation, left for the cipher and right for the inverse
    function automatic logic [127:0] shift_rows(input logic [127:0] t, input logic backward);
        logic [127:0] s;
        int src;
        s = '0;
        for (int row = 0; row < 4; row++) begin
            for (int col = 0; col < 4; col++) begin
                src = backward ? ((col + 4 - row) % 4) : ((col + row) % 4);
                s[8*(col*4+row) +: 8] = t[8*(src*4+row) +: 8];
            end
        end
        return s;
    endfunction

    // one column through the configured matrix
    function automatic logic [31:0] mix_column(input logic [31:0] c, input logic [127:0] mat,
                                               input logic [8:0] poly);
        logic [31:0] o;
        logic [7:0]  acc;
        o = '0;
        for (int row = 0; row < 4; row++) begin
            acc = '0;
            for (int j = 0; j < 4; j++) begin
                acc = acc ^ gmul(mat[8*(row+4*j) +: 8], c[8*j +: 8], poly);
            end
            o[8*row +: 8] = acc;
        end
        return o;
    endfunction

endpackage

[hdl/aes_block_cipher_configurable_field.sv]
// aes_block_cipher_configurable_field: top level with configuration registers and memories
// depends on acf_pkg, acf_ram, acf_builder, acf_core
//
// Ten-round AES-128 cipher and inverse cipher over a configurable GF(2^8) field and
// configurable mixing matrices. A block passes through the first key addition, the nine
// full rounds (byte substitution, column mix and key addition) and the final round, which
// has no column mix, and its result is then loaded into the output register. The pace
// is set by the one read port of the table memory, which serves one substituted byte
// per cycle. After reset and after every register write the block rebuilds its tables
// and round keys and holds its input stalled meanwhile: it first clears the inverse
// table, then works each of the 256 table entries through the shift-and-subtract steps
// and remainder swaps of the polynomial division, and then runs the key schedule round
// by round. One block is worked on at a time; a finished result waits in the output
// register while the next block is taken.
module aes_block_cipher_configurable_field import acf_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_W-1:0]  i_cfg_index,
    input  logic [63:0]       i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_operation,
    input  logic [63:0]       i_block_low,
    input  logic [63:0]       i_block_high,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [63:0]       o_result_low,
    output logic [63:0]       o_result_high
);
    logic [8:0]  r_poly;
    logic [63:0] r_key_lo, r_key_hi, r_mix_lo, r_mix_hi, r_inv_lo, r_inv_hi;
    t_cfg        cfg;
    logic        restart;
    logic        built;
    t_tab_req    b_tab;
    t_key_wr     b_key;
    logic [TAB_AW-1:0] core_tab_raddr, tab_raddr;
    logic [7:0]        tab_rdata;
    logic [KEY_AW-1:0] key_raddr;
    logic [63:0]       key_rdata;

    assign restart = i_cfg_we && (i_cfg_index < CFG_COUNT);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poly <= POLY_RESET;
            r_key_lo <= '0;
            r_key_hi <= '0;
            r_mix_lo <= '0;
            r_mix_hi <= '0;
            r_inv_lo <= '0;
            r_inv_hi <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_POLY:   r_poly <= i_cfg_data[8:0];
                CFG_KEY_LO: r_key_lo <= i_cfg_data;
                CFG_KEY_HI: r_key_hi <= i_cfg_data;
                CFG_MIX_LO: r_mix_lo <= i_cfg_data;
                CFG_MIX_HI: r_mix_hi <= i_cfg_data;
                CFG_INV_LO: r_inv_lo <= i_cfg_data;
                CFG_INV_HI: r_inv_hi <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg.poly = r_poly;
    assign cfg.key = {r_key_hi, r_key_lo};
    assign cfg.mix = {r_mix_hi, r_mix_lo};
    assign cfg.inv = {r_inv_hi, r_inv_lo};

    // table memory read port belongs to the builder until the tables are ready
    assign tab_raddr = built ? core_tab_raddr : b_tab.raddr;

    acf_ram #(.WIDTH(8), .DEPTH(TAB_DEPTH)) u_tab_ram (
        .i_clk   (i_clk),
        .i_we    (b_tab.we),
        .i_waddr (b_tab.waddr),
        .i_wdata (b_tab.wdata),
        .i_raddr (tab_raddr),
        .o_rdata (tab_rdata)
    );

    acf_ram #(.WIDTH(64), .DEPTH(KEY_WORDS)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (b_key.we),
        .i_waddr (b_key.addr),
        .i_wdata (b_key.data),
        .i_raddr (key_raddr),
        .o_rdata (key_rdata)
    );

    acf_builder u_builder (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_restart   (restart),
        .i_cfg       (cfg),
        .i_tab_rdata (tab_rdata),
        .o_tab       (b_tab),
        .o_key       (b_key),
        .o_done      (built)
    );

    acf_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_built       (built),
        .i_cfg         (cfg),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_operation   (i_operation),
        .i_block_low   (i_block_low),
        .i_block_high  (i_block_high),
        .o_tab_raddr   (core_tab_raddr),
        .i_tab_rdata   (tab_rdata),
        .o_key_raddr   (key_raddr),
        .i_key_rdata   (key_rdata),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_result_low  (o_result_low),
        .o_result_high (o_result_high)
    );
endmodule

[hdl/acf_ram.sv]
// acf_ram: generic single write, single read port RAM with registered read
// no dependencies
module acf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[hdl/acf_builder.sv]
// acf_builder: fills the substitution tables and the round key memory from configuration
// depends on acf_pkg; drives the table memory and the key memory write port
module acf_builder import acf_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_restart,
    input  t_cfg     i_cfg,
    input  logic [7:0] i_tab_rdata,
    output t_tab_req o_tab,
    output t_key_wr  o_key,
    output logic     o_done
);
    typedef enum logic [8:0] {
        B_CLEAR = 9'b000000001,
        B_ELEM  = 9'b000000010,
        B_DIV   = 9'b000000100,
        B_WS    = 9'b000001000,
        B_WI    = 9'b000010000,
        B_KW0   = 9'b000100000,
        B_KW1   = 9'b001000000,
        B_KS    = 9'b010000000,
        B_DONE  = 9'b100000000
    } t_bstate;

    t_bstate r_state, n_state;
    logic [7:0]   r_i, n_i;
    logic [15:0]  r_b1, n_b1, r_n1, n_n1;
    logic [8:0]   r_b2, n_b2, r_r, n_r;
    logic [7:0]   r_inv, n_inv, r_sb, n_sb;
    logic [127:0] r_ek, n_ek;
    logic [7:0]   r_rc, n_rc;
    logic [KR_W-1:0] r_kr, n_kr;
    logic [2:0]   r_cnt, n_cnt;
    logic [31:0]  r_w, n_w;

    logic [8:0]   pv;
    logic [3:0]   sh;
    logic [31:0]  wv;
    logic [127:0] ek_new;
    logic [1:0]   rd_j;

    assign pv = {1'b1, i_cfg.poly[7:0]};
    assign sh = deg9(r_r) - deg9(r_b2);
    assign rd_j = r_cnt[1:0] + 2'd1;

    // next round key from the four substituted bytes
    always_comb begin
        wv = r_w;
        wv[31:24] = i_tab_rdata;
        wv[7:0] = wv[7:0] ^ r_rc;
        ek_new = '0;
        for (int k = 0; k < 4; k++) begin
            ek_new[8*k +: 8] = wv[8*k +: 8] ^ r_ek[8*k +: 8];
        end
        for (int k = 4; k < 16; k++) begin
            ek_new[8*k +: 8] = ek_new[8*(k-4) +: 8] ^ r_ek[8*k +: 8];
        end
    end

    // build sequencer
    always_comb begin
        n_state = r_state;
        n_i = r_i;
        n_b1 = r_b1;
        n_n1 = r_n1;
        n_b2 = r_b2;
        n_r = r_r;
        n_inv = r_inv;
        n_sb = r_sb;
        n_ek = r_ek;
        n_rc = r_rc;
        n_kr = r_kr;
        n_cnt = r_cnt;
        n_w = r_w;
        o_tab = '0;
        o_key = '0;
        o_done = 1'b0;
        case (r_state)
            B_CLEAR: begin
                o_tab.we = 1'b1;
                o_tab.waddr = {1'b1, r_i};
                o_tab.wdata = '0;
                n_i = r_i + 8'd1;
                if (r_i == 8'hFF) n_state = B_ELEM;
            end
            B_ELEM: begin
                n_b1 = 16'd1;
                n_b2 = {1'b0, r_i};
                n_r = pv;
                n_n1 = '0;
                n_state = B_DIV;
            end
            B_DIV: begin
                if (r_i == 8'd0) begin
                    n_inv = '0;
                    n_state = B_WS;
                end else if (r_b2 <= 9'd1) begin
                    n_inv = r_b1[7:0];
                    n_state = B_WS;
                end else if (r_r != 9'd0 && deg9(r_r) >= deg9(r_b2)) begin
                    n_r = r_r ^ (r_b2 << sh);
                    n_n1 = r_n1 ^ (r_b1 << sh);
                end else begin
                    // one remainder step finished
                    n_b1 = r_n1;
                    n_b2 = r_r;
                    n_r = r_b2;
                    n_n1 = r_b1;
                end
            end
            B_WS: begin
                o_tab.we = 1'b1;
                o_tab.waddr = {1'b0, r_i};
                o_tab.wdata = affine(r_inv);
                n_sb = affine(r_inv);
                n_state = B_WI;
            end
            B_WI: begin
                o_tab.we = 1'b1;
                o_tab.waddr = {1'b1, r_sb};
                o_tab.wdata = r_i;
                n_i = r_i + 8'd1;
                if (r_i == 8'hFF) begin
                    n_ek = i_cfg.key;
                    n_rc = 8'd1;
                    n_kr = '0;
                    n_state = B_KW0;
                end else begin
                    n_state = B_ELEM;
                end
            end
            B_KW0: begin
                o_key.we = 1'b1;
                o_key.addr = KEY_AW'({r_kr, 1'b0});
                o_key.data = r_ek[63:0];
                n_state = B_KW1;
            end
            B_KW1: begin
                o_key.we = 1'b1;
                o_key.addr = KEY_AW'({r_kr, 1'b1});
                o_key.data = r_ek[127:64];
                n_cnt = '0;
                n_state = (r_kr == LAST_ROUND) ? B_DONE : B_KS;
            end
            B_KS: begin
                o_tab.raddr = {1'b0, r_ek[96 + 8*rd_j +: 8]};
                if (r_cnt != 3'd0) n_w[8*(r_cnt[1:0] - 2'd1) +: 8] = i_tab_rdata;
                n_cnt = r_cnt + 3'd1;
                if (r_cnt == 3'd4) begin
                    n_ek = ek_new;
                    n_rc = gmul(r_rc, 8'h02, i_cfg.poly);
                    n_kr = r_kr + 1'b1;
                    n_state = B_KW0;
                end
            end
            B_DONE: begin
                o_done = 1'b1;
            end
            default: begin
                n_state = B_CLEAR;
            end
        endcase
    end

    // state registers, restart on reset or on any register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_state <= B_CLEAR;
            r_i <= '0;
            r_kr <= '0;
            r_cnt <= '0;
        end else begin
            r_state <= n_state;
            r_i <= n_i;
            r_kr <= n_kr;
            r_cnt <= n_cnt;
        end
        r_b1 <= n_b1;
        r_n1 <= n_n1;
        r_b2 <= n_b2;
        r_r <= n_r;
        r_inv <= n_inv;
        r_sb <= n_sb;
        r_ek <= n_ek;
        r_rc <= n_rc;
        r_w <= n_w;
    end
endmodule

[hdl/acf_core.sv]
// acf_core: round sequencer and state datapath for encryption and decryption
// depends on acf_pkg; reads the table memory and the round key memory
module acf_core import acf_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_built,
    input  t_cfg              i_cfg,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_operation,
    input  logic [63:0]       i_block_low,
    input  logic [63:0]       i_block_high,
    output logic [TAB_AW-1:0] o_tab_raddr,
    input  logic [7:0]        i_tab_rdata,
    output logic [KEY_AW-1:0] o_key_raddr,
    input  logic [63:0]       i_key_rdata,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output logic [63:0]       o_result_low,
    output logic [63:0]       o_result_high
);
    typedef enum logic [4:0] {
        C_IDLE = 5'b00001,
        C_KEY  = 5'b00010,
        C_SUB  = 5'b00100,
        C_MIX  = 5'b01000,
        C_FIN  = 5'b10000
    } t_cstate;

    localparam logic [4:0] SUB_LAST = 5'd16;

    t_cstate r_state, n_state;
    logic            r_op, n_op;
    logic [127:0]    r_st, n_st;
    logic [KR_W-1:0] r_round, n_round;
    logic [4:0]      r_cnt, n_cnt;
    logic            r_out_valid, n_out_valid;
    logic [127:0]    r_res, n_res;

    logic [KR_W-1:0] kidx;
    logic [127:0]    sub_tmp;
    logic [3:0]      sub_wr;
    logic            accept;
    logic            last;

    assign accept = i_in_valid && !o_in_stall;
    assign o_in_stall = !(r_state == C_IDLE && i_built);
    assign last = (r_round == LAST_ROUND);
    assign kidx = r_op ? (LAST_ROUND - r_round) : r_round;
    assign o_key_raddr = KEY_AW'({kidx, r_cnt[0]});
    assign o_tab_raddr = {r_op, r_st[8*r_cnt[3:0] +: 8]};
    assign sub_wr = 4'(r_cnt - 5'd1);

    // substituted byte lands in the cycle after its lookup
    always_comb begin
        sub_tmp = r_st;
        if (r_cnt != 5'd0) sub_tmp[8*sub_wr +: 8] = i_tab_rdata;
    end

    // round sequencer
    always_comb begin
        n_state = r_state;
        n_op = r_op;
        n_st = r_st;
        n_round = r_round;
        n_cnt = r_cnt;
        n_out_valid = r_out_valid && i_out_stall;
        n_res = r_res;
        case (r_state)
            C_IDLE: begin
                if (accept) begin
                    n_op = i_operation;
                    n_st = {i_block_high, i_block_low};
                    n_round = '0;
                    n_cnt = '0;
                    n_state = C_KEY;
                end
            end
            C_KEY: begin
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd1) n_st[63:0] = r_st[63:0] ^ i_key_rdata;
                if (r_cnt == 5'd2) begin
                    n_st[127:64] = r_st[127:64] ^ i_key_rdata;
                    n_cnt = '0;
                    if (!r_op) begin
                        if (last) begin
                            n_state = C_FIN;
                        end else begin
                            n_round = r_round + 1'b1;
                            n_state = C_SUB;
                        end
                    end else if (r_round == '0) begin
                        n_round = r_round + 1'b1;
                        n_state = C_SUB;
                    end else begin
                        n_state = last ? C_FIN : C_MIX;
                    end
                end
            end
            C_SUB: begin
                n_st = sub_tmp;
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == SUB_LAST) begin
                    n_st = shift_rows(sub_tmp, r_op);
                    n_cnt = '0;
                    n_state = (r_op || last) ? C_KEY : C_MIX;
                end
            end
            C_MIX: begin
                n_st[32*r_cnt[1:0] +: 32] = mix_column(r_st[32*r_cnt[1:0] +: 32],
                                                       r_op ? i_cfg.inv : i_cfg.mix,
                                                       i_cfg.poly);
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd3) begin
                    n_cnt = '0;
                    if (r_op) begin
                        n_round = r_round + 1'b1;
                        n_state = C_SUB;
                    end else begin
                        n_state = C_KEY;
                    end
                end
            end
            C_FIN: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_res = r_st;
                    n_out_valid = 1'b1;
                    n_state = C_IDLE;
                end
            end
            default: begin
                n_state = C_IDLE;
            end
        endcase
    end

    // registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_out_valid <= 1'b0;
            r_cnt <= '0;
            r_round <= '0;
        end else begin
            r_state <= n_state;
            r_out_valid <= n_out_valid;
            r_cnt <= n_cnt;
            r_round <= n_round;
        end
        r_op <= n_op;
        r_st <= n_st;
        r_res <= n_res;
    end

    assign o_out_valid = r_out_valid;
    assign o_result_low = r_res[63:0];
    assign o_result_high = r_res[127:64];
endmodule

[hdl/acf_checker.sv]
// acf_checker: port-level assertions for the configurable-field AES top level
// depends on acf_pkg; bound to aes_block_cipher_configurable_field
module acf_checker import acf_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_cfg_we,
    input logic [CFG_W-1:0] i_cfg_index,
    input logic             i_in_valid,
    input logic             o_in_stall,
    input logic             o_out_valid,
    input logic             i_out_stall,
    input logic [63:0]      o_result_low,
    input logic [63:0]      o_result_high
);
    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_result_low)
                                       && $stable(o_result_high))
        else $error("stalled result changed");

    // one block at a time: busy right after a transaction
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken again right after a transaction");

    // no result can appear right after a block is taken
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> !$rose(o_out_valid))
        else $error("result appeared one cycle after a transaction");

    // a register write starts a rebuild, which stalls the input
    a_cfg_rebuild: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we && (i_cfg_index < CFG_COUNT) |=> o_in_stall)
        else $error("input not stalled after a register write");
endmodule

bind aes_block_cipher_configurable_field acf_checker u_acf_checker (.*);

[tb/sv/aes_block_cipher_configurable_field_tb.sv]
// aes_block_cipher_configurable_field_tb: self-checking bench for the configurable-field aes core
// depends on acf_pkg and aes_block_cipher_configurable_field; predicts every block in-bench
module aes_block_cipher_configurable_field_tb;
    import acf_pkg::*;

    localparam int HALF_PERIOD = 5;
    localparam int STALL_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 300;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [CFG_W-1:0]  i_cfg_index;
    logic [63:0]       i_cfg_data;
    logic              i_in_valid;
    logic              o_in_stall;
    logic              i_operation;
    logic [63:0]       i_block_low;
    logic [63:0]       i_block_high;
    logic              o_out_valid;
    logic              i_out_stall;
    logic [63:0]       o_result_low;
    logic [63:0]       o_result_high;

    aes_block_cipher_configurable_field u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_operation   (i_operation),
        .i_block_low   (i_block_low),
        .i_block_high  (i_block_high),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_result_low  (o_result_low),
        .o_result_high (o_result_high)
    );

    // clock
    initial i_clk = 1'b0;
    always #HALF_PERIOD i_clk = ~i_clk;

    typedef enum logic { OP_ENCRYPT = 1'b0, OP_DECRYPT = 1'b1 } t_op;

    // shadow of the configuration and the derived tables
    logic [8:0]   cur_poly;
    logic [127:0] cur_key, cur_mix, cur_inv;
    logic [7:0]   sbox_q [256];
    logic [7:0]   inv_sbox_q [256];
    logic [7:0]   rcon_q [ROUND_COUNT];
    logic [127:0] round_key_q [ROUND_COUNT+1];

    logic [127:0] expected_blocks [$];
    int           errors;
    bit           idle_on;
    int           hold_cycles;
    int           quiet_cycles;

    // carry-less product truncated to 16 bits
    function automatic logic [31:0] clmul(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] acc;
        acc = '0;
        for (int i = 0; i < 16; i++) if (b[i]) acc ^= a << i;
        return acc & 32'hFFFF;
    endfunction

    function automatic int deg_of(input logic [31:0] v);
        int d;
        d = 0;
        for (int i = 0; i < 32; i++) if (v[i]) d = i;
        return d;
    endfunction

    function automatic logic [7:0] fmul(input logic [7:0] a, input logic [7:0] b);
        logic [31:0] acc, p;
        acc = clmul({24'd0, a}, {24'd0, b});
        p = {23'd0, 1'b1, cur_poly[7:0]};
        for (int bt = 15; bt >= 8; bt--) if (acc[bt]) acc ^= p << (bt - 8);
        return acc[7:0];
    endfunction

    // extended euclid, stops at remainder 0 or 1 even for reducible polynomials
    function automatic logic [7:0] finv(input logic [7:0] v);
        logic [31:0] a0, a1, a2, b0, b1, b2, q, r, n0, n1;
        int da, db;
        a0 = 1; a1 = 0; a2 = {23'd0, 1'b1, cur_poly[7:0]};
        b0 = 0; b1 = 1; b2 = {24'd0, v};
        for (int it = 0; it < 32 && b2 > 1; it++) begin
            q = 0; r = a2;
            da = deg_of(a2); db = deg_of(b2);
            while (da >= db && r != 0) begin
                r ^= b2 << (da - db);
                q |= 32'd1 << (da - db);
                da = deg_of(r);
            end
            n0 = (a0 ^ clmul(q, b0)) & 32'hFFFF;
            n1 = (a1 ^ clmul(q, b1)) & 32'hFFFF;
            a0 = b0; a1 = b1; a2 = b2;
            b0 = n0; b1 = n1; b2 = r;
        end
        return b1[7:0];
    endfunction

    // rebuild substitution tables, round constants and round keys
    task automatic rebuild_tables();
        logic [7:0] iv, s;
        logic [7:0] ek [16*(ROUND_COUNT+1)];
        logic [7:0] w [4];
        int base;
        for (int i = 0; i < 256; i++) begin
            iv = (i == 0) ? 8'd0 : finv(8'(i));
            for (int j = 0; j < 8; j++)
                s[j] = iv[j] ^ iv[(j+4)%8] ^ iv[(j+5)%8] ^ iv[(j+6)%8] ^ iv[(j+7)%8]
                     ^ AFFINE_CONST[j];
            sbox_q[i] = s;
        end
        for (int i = 0; i < 256; i++) inv_sbox_q[i] = 8'd0;
        for (int i = 0; i < 256; i++) inv_sbox_q[sbox_q[i]] = 8'(i);
        rcon_q[0] = 8'd1;
        for (int i = 1; i < ROUND_COUNT; i++) rcon_q[i] = fmul(rcon_q[i-1], 8'd2);
        for (int i = 0; i < 16; i++) ek[i] = cur_key[8*i +: 8];
        for (int r = 0; r < ROUND_COUNT; r++) begin
            base = 16 * (r + 1);
            for (int j = 0; j < 4; j++) w[j] = sbox_q[ek[base - 4 + ((j + 1) % 4)]];
            w[0] ^= rcon_q[r];
            for (int i = 0; i < 16; i++) begin
                ek[base+i] = w[i%4] ^ ek[base+i-16];
                w[i%4] = ek[base+i];
            end
        end
        for (int r = 0; r <= ROUND_COUNT; r++)
            for (int i = 0; i < 16; i++) round_key_q[r][8*i +: 8] = ek[16*r+i];
    endtask

    function automatic logic [127:0] rotate(input logic [127:0] t, input bit backward);
        logic [127:0] s;
        int src;
        for (int row = 0; row < 4; row++)
            for (int col = 0; col < 4; col++) begin
                src = backward ? ((col + 4 - row) % 4) : ((col + row) % 4);
                s[8*(col*4+row) +: 8] = t[8*(src*4+row) +: 8];
            end
        return s;
    endfunction

    function automatic logic [127:0] mix_state(input logic [127:0] t, input logic [127:0] m);
        logic [127:0] s;
        logic [7:0] acc;
        for (int col = 0; col < 4; col++)
            for (int row = 0; row < 4; row++) begin
                acc = '0;
                for (int j = 0; j < 4; j++)
                    acc ^= fmul(m[8*(row+4*j) +: 8], t[8*(col*4+j) +: 8]);
                s[8*(col*4+row) +: 8] = acc;
            end
        return s;
    endfunction

    function automatic logic [127:0] sub_state(input logic [127:0] t, input bit inverse);
        logic [127:0] s;
        for (int i = 0; i < 16; i++)
            s[8*i +: 8] = inverse ? inv_sbox_q[t[8*i +: 8]] : sbox_q[t[8*i +: 8]];
        return s;
    endfunction

    // full cipher or inverse cipher of one block
    function automatic logic [127:0] cipher_block(input t_op op, input logic [127:0] blk);
        logic [127:0] s;
        s = blk;
        if (op == OP_ENCRYPT) begin
            s ^= round_key_q[0];
            for (int r = 1; r <= ROUND_COUNT; r++) begin
                s = rotate(sub_state(s, 1'b0), 1'b0);
                if (r != ROUND_COUNT) s = mix_state(s, cur_mix);
                s ^= round_key_q[r];
            end
        end else begin
            s ^= round_key_q[ROUND_COUNT];
            for (int r = ROUND_COUNT; r >= 1; r--) begin
                s = sub_state(rotate(s, 1'b1), 1'b1);
                s ^= round_key_q[r-1];
                if (r != 1) s = mix_state(s, cur_inv);
            end
        end
        return s;
    endfunction

    // receiver stall: a long hold when requested, otherwise random bursts while idle_on is set
    int stall_burst;
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            i_out_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end else if (stall_burst > 0) begin
            i_out_stall <= 1'b1;
            stall_burst <= stall_burst - 1;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            i_out_stall <= 1'b1;
            stall_burst <= $urandom_range(0, 9);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // result check and watchdog
    always @(posedge i_clk) begin
        logic [127:0] exp_blk;
        if (i_rst_n && ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_blocks.size() == 0) begin
                $error("unexpected result transaction %h_%h", o_result_high, o_result_low);
                errors++;
            end else begin
                exp_blk = expected_blocks.pop_front();
                if (o_result_low !== exp_blk[63:0]) begin
                    $error("result_low expected %h actual %h", exp_blk[63:0], o_result_low);
                    errors++;
                end
                if (o_result_high !== exp_blk[127:64]) begin
                    $error("result_high expected %h actual %h", exp_blk[127:64],
                           o_result_high);
                    errors++;
                end
            end
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // send one block, waiting for the handshake
    task automatic send_block(input t_op op, input logic [127:0] blk);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
            repeat ($urandom_range(0, 9)) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid   = 1'b1;
        i_operation  = op;
        i_block_low  = blk[63:0];
        i_block_high = blk[127:64];
        do @(posedge i_clk); while (o_in_stall);
        expected_blocks.push_back(cipher_block(op, blk));
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (expected_blocks.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // register write, only with the block idle
    task automatic write_reg(input logic [CFG_W-1:0] idx, input logic [63:0] data);
        drain();
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            CFG_POLY:   cur_poly = data[8:0];
            CFG_KEY_LO: cur_key[63:0] = data;
            CFG_KEY_HI: cur_key[127:64] = data;
            CFG_MIX_LO: cur_mix[63:0] = data;
            CFG_MIX_HI: cur_mix[127:64] = data;
            CFG_INV_LO: cur_inv[63:0] = data;
            CFG_INV_HI: cur_inv[127:64] = data;
            default: ;
        endcase
        rebuild_tables();
    endtask

    function automatic logic [127:0] rand_block();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    task automatic load_standard_matrices();
        write_reg(CFG_MIX_LO, 64'h0101_0203_0301_0102);
        write_reg(CFG_MIX_HI, 64'h0203_0101_0102_0301);
        write_reg(CFG_INV_LO, 64'h0d09_0e0b_0b0d_090e);
        write_reg(CFG_INV_HI, 64'h0e0b_0d09_090e_0b0d);
    endtask

    // reset defaults: zero key and zero matrices
    task automatic test_reset_defaults();
        send_block(OP_ENCRYPT, '0);
        send_block(OP_DECRYPT, '0);
        send_block(OP_ENCRYPT, '1);
        send_block(OP_DECRYPT, '1);
    endtask

    // standard matrices with extreme keys and data
    task automatic test_directed_blocks();
        load_standard_matrices();
        write_reg(CFG_KEY_LO, 64'h0706_0504_0302_0100);
        write_reg(CFG_KEY_HI, 64'h0f0e_0d0c_0b0a_0908);
        send_block(OP_ENCRYPT, '0);
        send_block(OP_ENCRYPT, '1);
        send_block(OP_DECRYPT, {4{32'hA5A5_5A5A}});
        send_block(OP_DECRYPT, {4{32'h5A5A_A5A5}});
        write_reg(CFG_KEY_LO, '1);
        write_reg(CFG_KEY_HI, '1);
        send_block(OP_ENCRYPT, 128'h0123_4567_89ab_cdef_fedc_ba98_7654_3210);
        send_block(OP_DECRYPT, '1);
    endtask

    // polynomial corner cases: bit 8 clear, reducible extremes, ignored index
    task automatic test_polynomials();
        write_reg(CFG_POLY, 64'hFFFF_FFFF_FFFF_FE1B);
        send_block(OP_ENCRYPT, rand_block());
        send_block(OP_DECRYPT, rand_block());
        write_reg(CFG_POLY, 64'h100);
        send_block(OP_ENCRYPT, rand_block());
        send_block(OP_DECRYPT, rand_block());
        write_reg(CFG_POLY, 64'h1FF);
        send_block(OP_ENCRYPT, rand_block());
        send_block(OP_DECRYPT, rand_block());
        write_reg(CFG_COUNT, rand_word());
        send_block(OP_ENCRYPT, rand_block());
        send_block(OP_DECRYPT, rand_block());
    endtask

    // random phases, each with a fresh configuration
    task automatic test_random_phases();
        int n;
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(CFG_POLY, (ph == 0) ? 64'h11B : rand_word());
            write_reg(CFG_KEY_LO, rand_word());
            write_reg(CFG_KEY_HI, rand_word());
            if (ph % 2 == 0) begin
                load_standard_matrices();
            end else begin
                write_reg(CFG_MIX_LO, rand_word());
                write_reg(CFG_MIX_HI, rand_word());
                write_reg(CFG_INV_LO, rand_word());
                write_reg(CFG_INV_HI, rand_word());
            end
            idle_on = (ph != 5);
            if (ph == 1) hold_cycles = 3000;
            n = 0;
            repeat (300) begin
                send_block(t_op'($urandom_range(0, 1)), rand_block());
                n++;
                if (ph == 2 && n == 150) drain();
            end
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_index  = CFG_POLY;
        i_cfg_data   = '0;
        i_in_valid   = 1'b0;
        i_operation  = OP_ENCRYPT;
        i_block_low  = '0;
        i_block_high = '0;
        i_out_stall  = 1'b0;
        errors       = 0;
        idle_on      = 1'b1;
        hold_cycles  = 0;
        stall_burst  = 0;
        quiet_cycles = 0;
        cur_poly     = POLY_RESET;
        cur_key      = '0;
        cur_mix      = '0;
        cur_inv      = '0;
        rebuild_tables();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_defaults();
        test_directed_blocks();
        test_polynomials();
        test_random_phases();

        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0 && expected_blocks.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
